>>> sv/lrm_pkg.sv
// lrm_pkg: shared types, constants and codes for the load and rate monitor.
// No dependencies; imported by lrm_div, load_and_rate_monitor_core and tb_top.
package lrm_pkg;

  localparam int DATA_W        = 32;
  localparam int LOAD_W        = 7;
  localparam int WIN_W         = 16;
  localparam int FUNC_W        = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int IN_DATA_W     = 4 * DATA_W;
  localparam int OUT_FIELDS_W  = LOAD_W + 5 * DATA_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int DIV_STEP_BITS = 2;

  localparam logic [WIN_W-1:0]  LOAD_WIN_RESET = 16'd500;
  localparam logic [WIN_W-1:0]  RATE_WIN_RESET = 16'd1000;
  localparam logic [DATA_W-1:0] PCT_CAP        = 32'd100;
  localparam logic [DATA_W-1:0] CYC_PER_PCT    = 32'd100;

  typedef enum logic [FUNC_W-1:0] {
    FN_BUSY_BEGIN = 2'd0,
    FN_BUSY_END   = 2'd1,
    FN_SERVICE    = 2'd2,
    FN_PEAK_CLR   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_WIN = 1'b0,
    CFG_RATE_WIN = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_UNIT,
    ST_PCT,
    ST_RX,
    ST_TX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/lrm_div.sv
// lrm_div: shared iterative unsigned divider, STEP_BITS quotient bits per cycle.
// Depends on lrm_pkg (DATA_W, div_req_t, div_rsp_t).
module lrm_div import lrm_pkg::*; #(
  parameter int STEP_BITS = DIV_STEP_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int ITERS = DATA_W / STEP_BITS;
  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dq_r, dq_nxt;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;

  always_comb begin
    logic [DATA_W:0] part;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int i = 0; i < STEP_BITS; i++) begin
      part   = {rem_nxt, dq_nxt[DATA_W-1]};
      dq_nxt = {dq_nxt[DATA_W-2:0], 1'b0};
      if (part >= {1'b0, dvs_r}) begin
        part      = part - {1'b0, dvs_r};
        dq_nxt[0] = 1'b1;
      end
      rem_nxt = part[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITERS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dq_r  <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

>>> sv/load_and_rate_monitor_core.sv
// load_and_rate_monitor_core: busy-time, load percent and error rate monitor.
// Flow: an accepted beat is registered and handled in ST_EXEC; busy begin/end and peak
// clear then go to ST_DONE, which loads the out register once it is free, while a service
// tick first makes up to four passes of the shared divider at 2 quotient bits per cycle.
// One item in flight: in_tready is high only in idle. Reset: synchronous, active
// low; all monitor state clears, windows return to 500 ms (load) and 1000 ms (rate).
module load_and_rate_monitor_core import lrm_pkg::*; #(
  parameter int DIV_STEPS = DIV_STEP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cycle_stamp, now_ms, rx_total, tx_total
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // load_percent, rx_rate, tx_rate, peak_rx_rate, peak_tx_rate, peak_busy_cycles
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIN_W-1:0]      cfg_data
);

  state_t state_r, state_nxt;

  func_t             func_r;
  logic [DATA_W-1:0] stamp_r, now_r, rx_r, tx_r;

  logic [WIN_W-1:0]  load_win_r, rate_win_r;

  logic [DATA_W-1:0] busy_start_r, busy_start_nxt;
  logic [DATA_W-1:0] busy_accum_r, busy_accum_nxt;
  logic [DATA_W-1:0] peak_busy_r, peak_busy_nxt;
  logic [DATA_W-1:0] lws_cyc_r, lws_cyc_nxt;
  logic [DATA_W-1:0] lws_ms_r, lws_ms_nxt;
  logic [LOAD_W-1:0] load_value_r, load_value_nxt;
  logic [DATA_W-1:0] rws_ms_r, rws_ms_nxt;
  logic [DATA_W-1:0] prev_rx_r, prev_rx_nxt;
  logic [DATA_W-1:0] prev_tx_r, prev_tx_nxt;
  logic [DATA_W-1:0] rx_rate_r, rx_rate_nxt;
  logic [DATA_W-1:0] tx_rate_r, tx_rate_nxt;
  logic [DATA_W-1:0] rx_peak_r, rx_peak_nxt;
  logic [DATA_W-1:0] tx_peak_r, tx_peak_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [WIN_W-1:0]  load_win_eff, rate_win_eff;
  logic [DATA_W-1:0] load_el, rate_el, win_cyc, busy_len;
  logic [DATA_W-1:0] rx_delta, tx_delta, rx_scaled, tx_scaled;
  logic              load_due, rate_due;

  lrm_div #(.STEP_BITS(DIV_STEPS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign load_win_eff = (load_win_r == '0) ? WIN_W'(1) : load_win_r;
  assign rate_win_eff = (rate_win_r == '0) ? WIN_W'(1) : rate_win_r;
  assign load_el      = now_r - lws_ms_r;
  assign rate_el      = now_r - rws_ms_r;
  assign load_due     = load_el >= {{(DATA_W-WIN_W){1'b0}}, load_win_eff};
  assign rate_due     = rate_el >= {{(DATA_W-WIN_W){1'b0}}, rate_win_eff};
  assign win_cyc      = stamp_r - lws_cyc_r;
  assign busy_len     = stamp_r - busy_start_r;
  // x * 1000 = x * 1024 - x * 16 - x * 8, modulo 2^32
  assign rx_delta     = rx_r - prev_rx_r;
  assign tx_delta     = tx_r - prev_tx_r;
  assign rx_scaled    = (rx_delta << 10) - (rx_delta << 4) - (rx_delta << 3);
  assign tx_scaled    = (tx_delta << 10) - (tx_delta << 4) - (tx_delta << 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_win_r   <= LOAD_WIN_RESET;
      rate_win_r   <= RATE_WIN_RESET;
      busy_start_r <= '0;
      busy_accum_r <= '0;
      peak_busy_r  <= '0;
      lws_cyc_r    <= '0;
      lws_ms_r     <= '0;
      load_value_r <= '0;
      rws_ms_r     <= '0;
      prev_rx_r    <= '0;
      prev_tx_r    <= '0;
      rx_rate_r    <= '0;
      tx_rate_r    <= '0;
      rx_peak_r    <= '0;
      tx_peak_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_start_r <= busy_start_nxt;
      busy_accum_r <= busy_accum_nxt;
      peak_busy_r  <= peak_busy_nxt;
      lws_cyc_r    <= lws_cyc_nxt;
      lws_ms_r     <= lws_ms_nxt;
      load_value_r <= load_value_nxt;
      rws_ms_r     <= rws_ms_nxt;
      prev_rx_r    <= prev_rx_nxt;
      prev_tx_r    <= prev_tx_nxt;
      rx_rate_r    <= rx_rate_nxt;
      tx_rate_r    <= tx_rate_nxt;
      rx_peak_r    <= rx_peak_nxt;
      tx_peak_r    <= tx_peak_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LOAD_WIN: load_win_r <= cfg_data;
          CFG_RATE_WIN: rate_win_r <= cfg_data;
          default:      load_win_r <= load_win_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    if (in_tvalid && in_tready) begin
      func_r  <= func_t'(in_tuser);
      stamp_r <= in_tdata[DATA_W-1:0];
      now_r   <= in_tdata[2*DATA_W-1:DATA_W];
      rx_r    <= in_tdata[3*DATA_W-1:2*DATA_W];
      tx_r    <= in_tdata[4*DATA_W-1:3*DATA_W];
    end
  end

  always_comb begin
    state_nxt        = state_r;
    busy_start_nxt   = busy_start_r;
    busy_accum_nxt   = busy_accum_r;
    peak_busy_nxt    = peak_busy_r;
    lws_cyc_nxt      = lws_cyc_r;
    lws_ms_nxt       = lws_ms_r;
    load_value_nxt   = load_value_r;
    rws_ms_nxt       = rws_ms_r;
    prev_rx_nxt      = prev_rx_r;
    prev_tx_nxt      = prev_tx_r;
    rx_rate_nxt      = rx_rate_r;
    tx_rate_nxt      = tx_rate_r;
    rx_peak_nxt      = rx_peak_r;
    tx_peak_nxt      = tx_peak_r;
    div_req          = '0;
    out_load         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (func_r)
          FN_BUSY_BEGIN: begin
            busy_start_nxt = stamp_r;
            state_nxt      = ST_DONE;
          end
          FN_BUSY_END: begin
            busy_accum_nxt = busy_accum_r + busy_len;
            if (busy_len > peak_busy_r) begin
              peak_busy_nxt = busy_len;
            end
            state_nxt = ST_DONE;
          end
          FN_SERVICE: begin
            if (load_due) begin
              div_req   = '{start: 1'b1, dividend: win_cyc, divisor: CYC_PER_PCT};
              state_nxt = ST_UNIT;
            end else if (rate_due) begin
              div_req   = '{start: 1'b1, dividend: rx_scaled, divisor: rate_el};
              state_nxt = ST_RX;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          FN_PEAK_CLR: begin
            peak_busy_nxt = '0;
            rx_peak_nxt   = '0;
            tx_peak_nxt   = '0;
            state_nxt     = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_UNIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            load_value_nxt = '0;
            busy_accum_nxt = '0;
            lws_cyc_nxt    = stamp_r;
            lws_ms_nxt     = now_r;
            if (rate_due) begin
              div_req   = '{start: 1'b1, dividend: rx_scaled, divisor: rate_el};
              state_nxt = ST_RX;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            div_req   = '{start: 1'b1, dividend: busy_accum_r, divisor: div_rsp.quotient};
            state_nxt = ST_PCT;
          end
        end
      end
      ST_PCT: begin
        if (div_rsp.done) begin
          load_value_nxt = (div_rsp.quotient > PCT_CAP) ? PCT_CAP[LOAD_W-1:0]
                                                         : div_rsp.quotient[LOAD_W-1:0];
          busy_accum_nxt = '0;
          lws_cyc_nxt    = stamp_r;
          lws_ms_nxt     = now_r;
          if (rate_due) begin
            div_req   = '{start: 1'b1, dividend: rx_scaled, divisor: rate_el};
            state_nxt = ST_RX;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RX: begin
        if (div_rsp.done) begin
          rx_rate_nxt = div_rsp.quotient;
          if (div_rsp.quotient > rx_peak_r) begin
            rx_peak_nxt = div_rsp.quotient;
          end
          div_req   = '{start: 1'b1, dividend: tx_scaled, divisor: rate_el};
          state_nxt = ST_TX;
        end
      end
      ST_TX: begin
        if (div_rsp.done) begin
          tx_rate_nxt = div_rsp.quotient;
          if (div_rsp.quotient > tx_peak_r) begin
            tx_peak_nxt = div_rsp.quotient;
          end
          prev_rx_nxt = rx_r;
          prev_tx_nxt = tx_r;
          rws_ms_nxt  = now_r;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_DATA_W'({peak_busy_r, tx_peak_r, rx_peak_r,
                                   tx_rate_r, rx_rate_r, load_value_r});
    end else begin
      out_tvalid_nxt = out_tvalid_r && !out_tready;
      out_tdata_nxt  = out_tdata_r;
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!div_rsp.busy && !div_rsp.done))
    else $error("input beat accepted with divider active");

  a_load_capped: assert property (@(posedge clk) disable iff (!rst_n)
    {{(DATA_W-LOAD_W){1'b0}}, load_value_r} <= PCT_CAP)
    else $error("load percent above cap");

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for load_and_rate_monitor_core (busy time, load %, error rates).
// Depends on lrm_pkg and the core RTL; drives stream beats and window writes and
// compares each out beat with its own in-bench monitor predictor.
`timescale 1ns / 100ps

module tb_top;
  import lrm_pkg::*;

  localparam int          RST_CYCLES  = 9;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          HOLD_LEN    = 400;
  localparam int          DRAIN_WAIT  = 100;
  localparam int          MAX_SHOWN   = 10;
  localparam bit [31:0]   PCT_MAX     = 32'd100;
  localparam bit [31:0]   CYC_PER_PCT = 32'd100;
  localparam bit [31:0]   MS_PER_S    = 32'd1000;

  typedef struct packed {
    bit [31:0] peak_busy;
    bit [31:0] peak_tx;
    bit [31:0] peak_rx;
    bit [31:0] tx_rate;
    bit [31:0] rx_rate;
    bit [6:0]  load_pct;
  } mon_rec_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // cycle_stamp, now_ms, rx_total, tx_total
  logic [FUNC_W-1:0]     in_tuser   = '0;  // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // load_percent, rx_rate, tx_rate, peak_rx_rate, peak_tx_rate, peak_busy_cycles
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [WIN_W-1:0]      cfg_data   = '0;

  load_and_rate_monitor_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  bit [15:0] load_win = LOAD_WIN_RESET;
  bit [15:0] rate_win = RATE_WIN_RESET;
  bit [31:0] busy_from, busy_sum, peak_busy_cyc;
  bit [31:0] load_cyc0, load_ms0, rate_ms0, rx_prev, tx_prev;
  bit [31:0] rx_rate_now, tx_rate_now, rx_rate_max, tx_rate_max;
  bit [6:0]  load_pct_now;

  mon_rec_t  exp_reports[$];
  mon_rec_t  got_rec, want_rec;
  int        mism_cnt, items_sent, reports_seen, load_updates, rate_updates;
  int        snd_idle_pct, rcv_idle_pct, rcv_hold;
  int        cycle_cnt;
  string     field_name[6] = '{"load_percent", "rx_rate", "tx_rate",
                               "peak_rx_rate", "peak_tx_rate", "peak_busy_cycles"};

  // traffic generator timeline
  bit [31:0] trk_cyc, trk_ms, trk_rx, trk_tx;

  function automatic bit [31:0] eff_window(bit [15:0] w);
    return (w == 16'd0) ? 32'd1 : {16'd0, w};
  endfunction

  function automatic bit [31:0] error_rate(bit [31:0] total, bit [31:0] prev, bit [31:0] el);
    bit [31:0] delta;
    delta = (total - prev) * MS_PER_S;
    return delta / el;
  endfunction

  function automatic mon_rec_t monitor_update(func_t f, bit [31:0] stamp, bit [31:0] now,
                                              bit [31:0] rx, bit [31:0] tx);
    bit [31:0] span, unit, pct;
    mon_rec_t  rec;
    case (f)
      FN_BUSY_BEGIN: busy_from = stamp;
      FN_BUSY_END: begin
        span = stamp - busy_from;
        busy_sum += span;
        if (span > peak_busy_cyc) peak_busy_cyc = span;
      end
      FN_SERVICE: begin
        span = now - load_ms0;
        if (span >= eff_window(load_win)) begin
          unit = (stamp - load_cyc0) / CYC_PER_PCT;
          pct  = 32'd0;
          if (unit != 32'd0) begin
            pct = busy_sum / unit;
            if (pct > PCT_MAX) pct = PCT_MAX;
          end
          load_pct_now = pct[6:0];
          busy_sum     = 32'd0;
          load_cyc0    = stamp;
          load_ms0     = now;
          load_updates++;
        end
        span = now - rate_ms0;
        if (span >= eff_window(rate_win)) begin
          rx_rate_now = error_rate(rx, rx_prev, span);
          tx_rate_now = error_rate(tx, tx_prev, span);
          if (rx_rate_now > rx_rate_max) rx_rate_max = rx_rate_now;
          if (tx_rate_now > tx_rate_max) tx_rate_max = tx_rate_now;
          rx_prev  = rx;
          tx_prev  = tx;
          rate_ms0 = now;
          rate_updates++;
        end
      end
      default: begin
        peak_busy_cyc = 32'd0;
        rx_rate_max   = 32'd0;
        tx_rate_max   = 32'd0;
      end
    endcase
    rec.load_pct  = load_pct_now;
    rec.rx_rate   = rx_rate_now;
    rec.tx_rate   = tx_rate_now;
    rec.peak_rx   = rx_rate_max;
    rec.peak_tx   = tx_rate_max;
    rec.peak_busy = peak_busy_cyc;
    return rec;
  endfunction

  function automatic bit [31:0] field_of(mon_rec_t r, int i);
    case (i)
      0:       return {25'd0, r.load_pct};
      1:       return r.rx_rate;
      2:       return r.tx_rate;
      3:       return r.peak_rx;
      4:       return r.peak_tx;
      default: return r.peak_busy;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rec = mon_rec_t'(out_tdata[OUT_FIELDS_W-1:0]);
      reports_seen++;
      if (exp_reports.size() == 0) begin
        if (mism_cnt < MAX_SHOWN) $display("unexpected out beat: %h", out_tdata);
        mism_cnt++;
      end else begin
        want_rec = exp_reports.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (field_of(got_rec, i) !== field_of(want_rec, i)) begin
            if (mism_cnt < MAX_SHOWN)
              $display("beat %0d %s: expected %0d, got %0d", reports_seen, field_name[i],
                       field_of(want_rec, i), field_of(got_rec, i));
            mism_cnt++;
          end
        end
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      out_tready = 1'b0;
      rcv_hold--;
    end else begin
      out_tready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycle_cnt, exp_reports.size());
      $display("[load_and_rate_monitor_core] ERROR");
      $finish;
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_item(input func_t f, input bit [31:0] stamp, input bit [31:0] now,
                           input bit [31:0] rx, input bit [31:0] tx);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = {tx, rx, now, stamp};
    do @(posedge clk); while (!in_tready);
    exp_reports.push_back(monitor_update(f, stamp, now, rx, tx));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (exp_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(input cfg_idx_t idx, input bit [15:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LOAD_WIN) load_win = val;
    else rate_win = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    send_item(FN_BUSY_END, 32'hFFFF_FFFF, $urandom, $urandom, $urandom);  // end without begin
    send_item(FN_PEAK_CLR, $urandom, $urandom, $urandom, $urandom);
    send_item(FN_BUSY_BEGIN, 32'hFFFF_FF00, $urandom, $urandom, $urandom);
    send_item(FN_BUSY_BEGIN, 32'hFFFF_FFF0, $urandom, $urandom, $urandom);  // newer begin wins
    send_item(FN_BUSY_END, 32'h0000_0100, $urandom, $urandom, $urandom);    // stamp wrap
    send_item(FN_SERVICE, 32'd50, 32'd499, 32'd5, 32'd7);                   // window not reached
    send_item(FN_SERVICE, 32'd99, 32'd500, 32'd5, 32'd7);                   // stamp span below CYC_PER_PCT
    send_item(FN_BUSY_BEGIN, 32'd100, $urandom, $urandom, $urandom);
    send_item(FN_BUSY_END, 32'd90_100, $urandom, $urandom, $urandom);
    send_item(FN_SERVICE, 32'd100_099, 32'd1000, 32'd3, 32'hFFFF_FFFF);
    send_item(FN_BUSY_BEGIN, 32'd200_000, $urandom, $urandom, $urandom);
    send_item(FN_BUSY_END, 32'h8003_0D40, $urandom, $urandom, $urandom);
    send_item(FN_SERVICE, 32'd100_349, 32'd1500, 32'd9, 32'hFFFF_FFFF);     // capped at 100
    send_item(FN_SERVICE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(FN_SERVICE, 32'h0000_1000, 32'h0000_0400, 32'd0, 32'hFFFF_0000);  // ms wrap
    send_item(FN_PEAK_CLR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_SERVICE, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(FN_BUSY_BEGIN, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_BUSY_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FN_SERVICE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_window_regs();
    write_window(CFG_LOAD_WIN, 16'hFFFF);
    write_window(CFG_RATE_WIN, 16'hFFFF);
    send_item(FN_SERVICE, $urandom, load_ms0 + 32'd65534, $urandom, $urandom);
    send_item(FN_SERVICE, $urandom, load_ms0 + 32'd65535, $urandom, $urandom);
    send_item(FN_SERVICE, $urandom, rate_ms0 + 32'd65534, $urandom, $urandom);
    send_item(FN_SERVICE, $urandom, rate_ms0 + 32'd65535, $urandom, $urandom);
    // zero window behaves as one
    write_window(CFG_LOAD_WIN, 16'd0);
    write_window(CFG_RATE_WIN, 16'd0);
    send_item(FN_SERVICE, $urandom, rate_ms0, $urandom, $urandom);
    send_item(FN_SERVICE, $urandom, rate_ms0 + 32'd1, $urandom, $urandom);
    write_window(CFG_LOAD_WIN, 16'd1);
    write_window(CFG_RATE_WIN, 16'd1);
    send_item(FN_SERVICE, $urandom, rate_ms0, $urandom, $urandom);
    send_item(FN_SERVICE, $urandom, rate_ms0 + 32'd1, $urandom, $urandom);
  endtask

  task automatic random_item();
    int unsigned pick, adv;
    pick    = $urandom_range(99);
    adv     = $urandom_range(1, 20000);
    trk_cyc = trk_cyc + adv;
    trk_ms  = trk_ms + adv / 1000 + 32'($urandom_range(3) == 0);
    if (pick < 30) begin
      send_item(FN_BUSY_BEGIN, trk_cyc, $urandom, $urandom, $urandom);
    end else if (pick < 60) begin
      send_item(FN_BUSY_END, trk_cyc, $urandom, $urandom, $urandom);
    end else if (pick < 88) begin
      trk_rx = trk_rx + (($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 40));
      trk_tx = trk_tx + (($urandom_range(19) == 0) ? $urandom : $urandom_range(0, 40));
      send_item(FN_SERVICE, trk_cyc, trk_ms, trk_rx, trk_tx);
    end else if (pick < 92) begin
      send_item(FN_PEAK_CLR, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_item(func_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(posedge clk);
    rcv_hold = HOLD_LEN;
    @(negedge clk);
    repeat (12) random_item();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
    write_window(CFG_LOAD_WIN, 16'($urandom_range(1, 200)));
    write_window(CFG_RATE_WIN, 16'($urandom_range(1, 400)));
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    trk_cyc = $urandom;
    trk_ms  = $urandom;
    trk_rx  = $urandom;
    trk_tx  = $urandom;
    repeat (n) random_item();
    wait_drained();
  endtask

  initial begin
    snd_idle_pct = 12;
    rcv_idle_pct = 68;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_window_regs();
    test_backpressure();
    test_random_traffic(640, 12, 68);
    test_random_traffic(640, 68, 12);
    test_random_traffic(640, 0, 0);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d items sent, %0d reports checked, %0d load and %0d rate window updates",
             items_sent, reports_seen, load_updates, rate_updates);
    $display("window regs at 0, 1 and 65535, long receiver hold-off, three idle mixes");
    if (mism_cnt == 0 && exp_reports.size() == 0) begin
      $display("[load_and_rate_monitor_core] OK");
    end else begin
      $display("%0d mismatches, %0d reports missing", mism_cnt, exp_reports.size());
      $display("[load_and_rate_monitor_core] ERROR");
    end
    $finish;
  end

endmodule
